[rtl/frac_pkg.sv]
// Shared definitions for the fraction arithmetic and reduction unit.
// Holds operation codes, datapath command and status types, default widths.
// Used by frac_ctrl, frac_datapath and fraction_arith_reduce_unit.
package frac_pkg;

	// Default operand width; results are 2W+1 (numerator) and 2W (denominator) bits
	localparam int OPERAND_WIDTH_DEF = 15;

	// Operation codes carried on the func field
	typedef logic [1:0] func_t;
	localparam func_t FUNC_ADD    = 2'd0;
	localparam func_t FUNC_MUL    = 2'd1;
	localparam func_t FUNC_DIV    = 2'd2;
	localparam func_t FUNC_REDUCE = 2'd3;

	// Datapath operations issued by the controller
	typedef logic [3:0] dp_op_t;
	localparam dp_op_t DP_IDLE      = 4'd0;
	localparam dp_op_t DP_LOAD      = 4'd1;
	localparam dp_op_t DP_SUM       = 4'd2;
	localparam dp_op_t DP_PASS      = 4'd3;
	localparam dp_op_t DP_N_MUL     = 4'd4;
	localparam dp_op_t DP_N_MAC     = 4'd5;
	localparam dp_op_t DP_D_MUL     = 4'd6;
	localparam dp_op_t DP_GCD_INIT  = 4'd7;
	localparam dp_op_t DP_GCD_TWOS  = 4'd8;
	localparam dp_op_t DP_GCD_STEP  = 4'd9;
	localparam dp_op_t DP_DIV_INIT  = 4'd10;
	localparam dp_op_t DP_DIV_STEP  = 4'd11;
	localparam dp_op_t DP_OUT       = 4'd12;

	// Multiplier operand pairs
	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MS_NA_DB = 3'd0;
	localparam mul_sel_t MS_NB_DA = 3'd1;
	localparam mul_sel_t MS_DA_DB = 3'd2;
	localparam mul_sel_t MS_NA_NB = 3'd3;
	localparam mul_sel_t MS_DA_NB = 3'd4;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;      // latched operation code
		logic  den_eq;    // left and right denominators match
		logic  both_even; // GCD operands both nonzero and even
		logic  gcd_end;   // one GCD operand reached zero
		logic  g_small;   // GCD below two, no division needed
		logic  div_last;  // final quotient bit in progress
	} dp_status_t;

endpackage

[rtl/frac_datapath.sv]
// Datapath of the fraction unit: operand registers, shared multiplier,
// binary GCD registers, two restoring dividers and the output register.
// Depends on frac_pkg for command and status types.
module frac_datapath #(
	parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                       clk,
	input  frac_pkg::dp_cmd_t          cmd,
	input  logic [1:0]                 func,
	input  logic [OPERAND_WIDTH-1:0]   num_a,
	input  logic [OPERAND_WIDTH-1:0]   den_a,
	input  logic [OPERAND_WIDTH-1:0]   num_b,
	input  logic [OPERAND_WIDTH-1:0]   den_b,
	output frac_pkg::dp_status_t       status,
	output logic [2*OPERAND_WIDTH:0]   num_out,
	output logic [2*OPERAND_WIDTH-1:0] den_out
);

	localparam int W  = OPERAND_WIDTH;
	localparam int NW = 2 * W + 1;
	localparam int DW = 2 * W;
	localparam int KW = $clog2(NW);
	localparam int CW = $clog2(NW);

	logic [1:0]    func_q;
	logic [W-1:0]  na_q, da_q, nb_q, db_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [NW-1:0] u_q, v_q;
	logic [KW-1:0] k_q;
	logic [NW-1:0] g_q;
	logic [NW-1:0] qn_q, qd_q;
	logic [NW-1:0] rn_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_out_q;
	logic [DW-1:0] den_out_q;

	logic [W-1:0]  mul_x, mul_y;
	logic [DW-1:0] prod;
	logic          u_ge_v;
	logic [NW-1:0] u_minus_v, v_minus_u;
	logic [NW-1:0] g_nx;
	logic [NW:0]   tn, td, gx;
	logic          tn_ge, td_ge;
	logic [NW:0]   rn_nx, rd_nx;

	// Select multiplier operands
	always_comb begin
		case (cmd.sel)
			frac_pkg::MS_NA_DB: begin mul_x = na_q; mul_y = db_q; end
			frac_pkg::MS_NB_DA: begin mul_x = nb_q; mul_y = da_q; end
			frac_pkg::MS_DA_DB: begin mul_x = da_q; mul_y = db_q; end
			frac_pkg::MS_NA_NB: begin mul_x = na_q; mul_y = nb_q; end
			frac_pkg::MS_DA_NB: begin mul_x = da_q; mul_y = nb_q; end
			default:            begin mul_x = na_q; mul_y = db_q; end
		endcase
	end

	assign prod = DW'(mul_x) * DW'(mul_y);

	// GCD step arithmetic
	assign u_ge_v    = u_q >= v_q;
	assign u_minus_v = u_q - v_q;
	assign v_minus_u = v_q - u_q;
	assign g_nx      = (u_q | v_q) << k_q;

	// Restoring division: shift in next dividend bit, subtract when it fits
	assign gx    = {1'b0, g_q};
	assign tn    = {rn_q, qn_q[NW-1]};
	assign td    = {rd_q, qd_q[NW-1]};
	assign tn_ge = tn >= gx;
	assign td_ge = td >= gx;
	assign rn_nx = tn_ge ? (tn - gx) : tn;
	assign rd_nx = td_ge ? (td - gx) : td;

	// Status toward the controller
	assign status.func      = func_q;
	assign status.den_eq    = (da_q == db_q);
	assign status.gcd_end   = (u_q == '0) || (v_q == '0);
	assign status.both_even = (u_q != '0) && (v_q != '0) && !u_q[0] && !v_q[0];
	assign status.g_small   = (g_q[NW-1:1] == '0);
	assign status.div_last  = (cnt_q == '0);

	// Advance datapath registers on each command
	always_ff @(posedge clk) begin
		case (cmd.op)
			frac_pkg::DP_LOAD: begin
				func_q <= func;
				na_q   <= num_a;
				da_q   <= den_a;
				nb_q   <= num_b;
				db_q   <= den_b;
			end
			frac_pkg::DP_SUM: begin
				n_q <= NW'(na_q) + NW'(nb_q);
				d_q <= DW'(da_q);
			end
			frac_pkg::DP_PASS: begin
				n_q <= NW'(na_q);
				d_q <= DW'(da_q);
			end
			frac_pkg::DP_N_MUL: n_q <= NW'(prod);
			frac_pkg::DP_N_MAC: n_q <= n_q + NW'(prod);
			frac_pkg::DP_D_MUL: d_q <= prod;
			frac_pkg::DP_GCD_INIT: begin
				u_q <= n_q;
				v_q <= NW'(d_q);
				k_q <= '0;
			end
			frac_pkg::DP_GCD_TWOS: begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end
			frac_pkg::DP_GCD_STEP: begin
				if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_ge_v) begin
					u_q <= u_minus_v >> 1;
				end else begin
					v_q <= v_minus_u >> 1;
				end
			end
			frac_pkg::DP_DIV_INIT: begin
				g_q   <= g_nx;
				qn_q  <= n_q;
				qd_q  <= NW'(d_q);
				rn_q  <= '0;
				rd_q  <= '0;
				cnt_q <= CW'(NW - 1);
			end
			frac_pkg::DP_DIV_STEP: begin
				qn_q  <= {qn_q[NW-2:0], tn_ge};
				qd_q  <= {qd_q[NW-2:0], td_ge};
				rn_q  <= rn_nx[NW-1:0];
				rd_q  <= rd_nx[NW-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			frac_pkg::DP_OUT: begin
				num_out_q <= status.g_small ? n_q : qn_q;
				den_out_q <= status.g_small ? d_q : qd_q[DW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign num_out = num_out_q;
	assign den_out = den_out_q;

endmodule

[rtl/frac_ctrl.sv]
// Controller of the fraction unit: sequences load, products, GCD, division
// and the output transfer, and owns the channel handshake flags.
// Depends on frac_pkg for command and status types.
module frac_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  frac_pkg::dp_status_t status,
	output frac_pkg::dp_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_OP1   = 4'd1;
	localparam logic [3:0] S_OP2   = 4'd2;
	localparam logic [3:0] S_OP3   = 4'd3;
	localparam logic [3:0] S_GINIT = 4'd4;
	localparam logic [3:0] S_TWOS  = 4'd5;
	localparam logic [3:0] S_GSTEP = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q, state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath command
	always_comb begin
		state_nx = state_q;
		cmd.op   = frac_pkg::DP_IDLE;
		cmd.sel  = frac_pkg::MS_NA_DB;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op   = frac_pkg::DP_LOAD;
					state_nx = S_OP1;
				end
			end
			S_OP1: begin
				case (status.func)
					frac_pkg::FUNC_ADD: begin
						if (status.den_eq) begin
							cmd.op   = frac_pkg::DP_SUM;
							state_nx = S_GINIT;
						end else begin
							cmd.op   = frac_pkg::DP_N_MUL;
							cmd.sel  = frac_pkg::MS_NA_DB;
							state_nx = S_OP2;
						end
					end
					frac_pkg::FUNC_MUL: begin
						cmd.op   = frac_pkg::DP_N_MUL;
						cmd.sel  = frac_pkg::MS_NA_NB;
						state_nx = S_OP3;
					end
					frac_pkg::FUNC_DIV: begin
						cmd.op   = frac_pkg::DP_N_MUL;
						cmd.sel  = frac_pkg::MS_NA_DB;
						state_nx = S_OP3;
					end
					default: begin
						cmd.op   = frac_pkg::DP_PASS;
						state_nx = S_GINIT;
					end
				endcase
			end
			S_OP2: begin
				cmd.op   = frac_pkg::DP_N_MAC;
				cmd.sel  = frac_pkg::MS_NB_DA;
				state_nx = S_OP3;
			end
			S_OP3: begin
				cmd.op   = frac_pkg::DP_D_MUL;
				cmd.sel  = (status.func == frac_pkg::FUNC_DIV) ? frac_pkg::MS_DA_NB
				                                                : frac_pkg::MS_DA_DB;
				state_nx = S_GINIT;
			end
			S_GINIT: begin
				cmd.op   = frac_pkg::DP_GCD_INIT;
				state_nx = S_TWOS;
			end
			S_TWOS: begin
				// strip common factors of two, then fall into the odd loop
				if (status.both_even) begin
					cmd.op = frac_pkg::DP_GCD_TWOS;
				end else if (status.gcd_end) begin
					cmd.op   = frac_pkg::DP_DIV_INIT;
					state_nx = S_DIV;
				end else begin
					cmd.op   = frac_pkg::DP_GCD_STEP;
					state_nx = S_GSTEP;
				end
			end
			S_GSTEP: begin
				if (status.gcd_end) begin
					cmd.op   = frac_pkg::DP_DIV_INIT;
					state_nx = S_DIV;
				end else begin
					cmd.op = frac_pkg::DP_GCD_STEP;
				end
			end
			S_DIV: begin
				if (status.g_small) begin
					state_nx = S_FIN;
				end else begin
					cmd.op = frac_pkg::DP_DIV_STEP;
					if (status.div_last) begin
						state_nx = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.op   = frac_pkg::DP_OUT;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Hold state and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.op == frac_pkg::DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/fraction_arith_reduce_unit.sv]
// Top level of the fraction arithmetic unit with reduction to lowest terms.
// Instantiates frac_ctrl and frac_datapath; depends on frac_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries func, num_a, den_a, num_b, den_b.
//   func selects add, multiply, divide (by the right fraction) or reduce of
//   the left fraction alone. Output channel (out_valid/out_stall) carries the
//   result num_out/den_out divided through by its greatest common divisor.
//   One item is processed at a time; in_stall is low only while idle.
//   After an input transfer the controller steps through products and setup,
//   the binary GCD loop (one shift or subtract per cycle; common-factor-of-two
//   shifts come first, then odd steps, on the 31-bit and 30-bit values for the
//   default 15-bit operands), restoring division when the divisor is two or
//   more, and the output transfer; the GCD loop and the bit-serial dividers
//   set the latency. A new item is taken the cycle after the result
//   enters the output register, so a waiting result does not block input.
//   Reset (arst_n low) returns the controller to idle and drops out_valid.
//   While out_stall is high the result holds; a finished item waits for the
//   output register before the next one is accepted.
module fraction_arith_reduce_unit #(
	parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [OPERAND_WIDTH-1:0]   num_a,
	input  logic [OPERAND_WIDTH-1:0]   den_a,
	input  logic [OPERAND_WIDTH-1:0]   num_b,
	input  logic [OPERAND_WIDTH-1:0]   den_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2*OPERAND_WIDTH:0]   num_out,
	output logic [2*OPERAND_WIDTH-1:0] den_out
);

	frac_pkg::dp_cmd_t    cmd;
	frac_pkg::dp_status_t status;

	frac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	frac_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.func    (func),
		.num_a   (num_a),
		.den_a   (den_a),
		.num_b   (num_b),
		.den_b   (den_b),
		.status  (status),
		.num_out (num_out),
		.den_out (den_out)
	);

endmodule

[rtl/frac_checker.sv]
// Port-level checks for fraction_arith_reduce_unit, attached by bind.
// Depends on the top level's ports, its OPERAND_WIDTH parameter and frac_pkg for the default width.
module frac_checker #(
	parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [2*OPERAND_WIDTH:0]   num_out,
	input logic [2*OPERAND_WIDTH-1:0] den_out
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(num_out) && $stable(den_out))
		else $error("result changed while stalled");

	// Busy after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transfer");

	// Lowest terms: two nonzero parts never share a factor of two
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(num_out != '0 && den_out != '0 && !num_out[0] && !den_out[0]))
		else $error("result not in lowest terms");

endmodule

bind fraction_arith_reduce_unit frac_checker #(
	.OPERAND_WIDTH (OPERAND_WIDTH)
) u_frac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.num_out   (num_out),
	.den_out   (den_out)
);

[sim/fraction_result_check.sv]
// Checker for fraction_arith_reduce_unit: watches both channels, predicts each
// reduced fraction and compares it with what the unit delivers.
// Depends on frac_pkg for the operation codes.
module fraction_result_check #(
	parameter int W = frac_pkg::OPERAND_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  frac_pkg::func_t func,
	input  logic [W-1:0]    num_a,
	input  logic [W-1:0]    den_a,
	input  logic [W-1:0]    num_b,
	input  logic [W-1:0]    den_b,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic [2*W:0]    num_out,
	input  logic [2*W-1:0]  den_out,
	output int              errors,
	output int              pending,
	output int              checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2*W:0]   num;
		logic [2*W-1:0] den;
	} fraction_t;

	fraction_t lowest_terms_q[$];
	fraction_t want;
	int        n_bad;
	int        n_ok;

	// Combine the two fractions, then divide both parts by their GCD
	function automatic fraction_t lowest_terms(frac_pkg::func_t op, logic [W-1:0] na,
			logic [W-1:0] da, logic [W-1:0] nb, logic [W-1:0] db);
		logic [63:0] n, d, x, y, r;
		fraction_t   res;
		case (op)
			frac_pkg::FUNC_ADD: begin
				if (da == db) begin
					n = 64'(na) + 64'(nb);
					d = 64'(da);
				end else begin
					n = 64'(na) * 64'(db) + 64'(nb) * 64'(da);
					d = 64'(da) * 64'(db);
				end
			end
			frac_pkg::FUNC_MUL: begin
				n = 64'(na) * 64'(nb);
				d = 64'(da) * 64'(db);
			end
			frac_pkg::FUNC_DIV: begin
				n = 64'(na) * 64'(db);
				d = 64'(da) * 64'(nb);
			end
			default: begin
				n = 64'(na);
				d = 64'(da);
			end
		endcase
		// Euclid; a zero part leaves the other as the divisor, 0/0 stays as is
		x = n;
		y = d;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		if (x >= 2) begin
			n = n / x;
			d = d / x;
		end
		res.num = n[2*W:0];
		res.den = d[2*W-1:0];
		return res;
	endfunction

	// Retire results before queueing new transfers, so a result can never match
	// an item accepted in the same cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_terms_q.delete();
			n_bad = 0;
			n_ok = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lowest_terms_q.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: unexpected result %0d/%0d", $realtime, num_out, den_out);
					n_bad++;
				end else begin
					want = lowest_terms_q.pop_front();
					if (num_out !== want.num || den_out !== want.den) begin
						if (n_bad < 10)
							$display("%0t: mismatch: expected %0d/%0d, got %0d/%0d",
								$realtime, want.num, want.den, num_out, den_out);
						n_bad++;
					end else begin
						n_ok++;
					end
				end
			end
			if (in_valid && !in_stall)
				lowest_terms_q.push_back(lowest_terms(func, num_a, den_a, num_b, den_b));
			errors <= n_bad;
			checked <= n_ok;
			pending <= lowest_terms_q.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top for fraction_arith_reduce_unit: clock, reset, stimulus and verdict.
// Depends on frac_pkg, the unit itself and fraction_result_check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = frac_pkg::OPERAND_WIDTH_DEF;
	localparam logic [W-1:0] MAXV = '1;
	localparam int RANDOM_ITEMS = 1700;
	localparam longint TIMEOUT_NS = 64'd15_000_000;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	frac_pkg::func_t func;
	logic [W-1:0]    num_a, den_a, num_b, den_b;
	logic            out_valid;
	logic            out_stall;
	logic [2*W:0]    num_out;
	logic [2*W-1:0]  den_out;

	int errors, pending, checked;
	int n_sent;
	int op_count[4];
	bit in_gaps_on;
	bit out_stalls_on;
	bit hold_out;
	int stall_left;

	fraction_arith_reduce_unit #(.OPERAND_WIDTH(W)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.num_out(num_out), .den_out(den_out)
	);

	fraction_result_check #(.W(W)) i_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.num_out(num_out), .den_out(den_out),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Operand mix: zeros, small values, powers of two and their neighbors, near full scale
	function automatic logic [W-1:0] pick_operand();
		int r;
		int k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, W - 1);
		if (r < 3)
			return '0;
		else if (r < 30)
			return W'($urandom_range(1, 16));
		else if (r < 45)
			return W'((1 << k) - $urandom_range(0, 1)) | W'(k == 0);
		else if (r < 55)
			return MAXV - W'($urandom_range(0, 15));
		return W'($urandom_range(1, int'(MAXV)));
	endfunction

	// Offer one item, hold it until the transfer, then idle for a while when a gap is drawn
	task automatic offer_item(input frac_pkg::func_t op, input logic [W-1:0] na,
			input logic [W-1:0] da, input logic [W-1:0] nb, input logic [W-1:0] db);
		int gap;
		@(negedge clk);
		func <= op;
		num_a <= na;
		den_a <= da;
		num_b <= nb;
		den_b <= db;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
		op_count[op]++;
		gap = in_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Random item, often with a factor shared by all parts so reduction has work to do
	task automatic offer_random();
		frac_pkg::func_t op;
		logic [W-1:0]    v[4];
		int              f;
		op = frac_pkg::func_t'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 35) begin
			f = $urandom_range(2, 200);
			foreach (v[j])
				v[j] = W'(f * $urandom_range(1, int'(MAXV) / f));
		end else begin
			foreach (v[j])
				v[j] = pick_operand();
		end
		if (op == frac_pkg::FUNC_ADD && $urandom_range(0, 99) < 20)
			v[3] = v[1];
		offer_item(op, v[0], v[1], v[2], v[3]);
	endtask

	// Receiver: random stall stretches, a quiet phase, and the long hold-off
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
			end else if (!out_stalls_on) begin
				stall_left = 0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 60) begin
				out_stall <= 1'b0;
			end else begin
				stall_left = pick_gap();
				out_stall <= 1'b1;
			end
		end
	end

	// Long hold-off on the output while the sender keeps offering items
	initial begin
		hold_out = 1'b0;
		wait (n_sent >= 500);
		@(posedge clk);
		hold_out = 1'b1;
		repeat (800)
			@(posedge clk);
		hold_out = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		int fails;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = frac_pkg::FUNC_ADD;
		num_a = '0;
		den_a = '0;
		num_b = '0;
		den_b = '0;
		n_sent = 0;
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: full-scale operands, every operation, zero parts
		offer_item(frac_pkg::FUNC_ADD, MAXV, MAXV, MAXV, MAXV);
		offer_item(frac_pkg::FUNC_ADD, MAXV, MAXV, MAXV, MAXV - 1);
		offer_item(frac_pkg::FUNC_ADD, MAXV, MAXV - 1, MAXV, MAXV);
		offer_item(frac_pkg::FUNC_ADD, 3, 8, 5, 8);
		offer_item(frac_pkg::FUNC_ADD, 1, 2, 1, 3);
		offer_item(frac_pkg::FUNC_MUL, MAXV, 1, MAXV, 1);
		offer_item(frac_pkg::FUNC_MUL, 1, MAXV, 1, MAXV);
		offer_item(frac_pkg::FUNC_MUL, 6, 35, 14, 9);
		offer_item(frac_pkg::FUNC_DIV, 1, MAXV, MAXV, 1);
		offer_item(frac_pkg::FUNC_DIV, MAXV, 1, 1, MAXV);
		offer_item(frac_pkg::FUNC_DIV, 4, 9, 8, 3);
		offer_item(frac_pkg::FUNC_REDUCE, MAXV, MAXV, 0, 0);
		offer_item(frac_pkg::FUNC_REDUCE, 1, 1, MAXV, MAXV);
		offer_item(frac_pkg::FUNC_REDUCE, 16384, 8192, 5, 7);
		offer_item(frac_pkg::FUNC_REDUCE, 0, 5, 1, 1);
		offer_item(frac_pkg::FUNC_REDUCE, 7, 0, 1, 1);
		offer_item(frac_pkg::FUNC_REDUCE, 0, 0, 3, 3);
		offer_item(frac_pkg::FUNC_ADD, 3, 0, 1, 4);
		offer_item(frac_pkg::FUNC_ADD, 0, 4, 0, 4);
		offer_item(frac_pkg::FUNC_DIV, 3, 4, 0, 5);
		offer_item(frac_pkg::FUNC_MUL, 0, 3, 5, 7);
		offer_item(frac_pkg::FUNC_MUL, 0, 0, 5, 7);
		offer_item(frac_pkg::FUNC_DIV, 0, 4, 0, 5);

		// Random part in phases: both sides idling, sender steady, receiver steady
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			in_gaps_on = ((i / 250) % 3) != 1;
			out_stalls_on = ((i / 250) % 3) != 2;
			offer_random();
		end
		@(negedge clk);
		in_valid <= 1'b0;
		out_stalls_on = 1'b1;

		// Drain, then give a late or extra result time to show up
		wait (pending == 0);
		repeat (200)
			@(posedge clk);
		fails = errors + pending;
		$display("summary: %0d items (add %0d, mul %0d, div %0d, reduce %0d), %0d results matched",
			n_sent, op_count[frac_pkg::FUNC_ADD], op_count[frac_pkg::FUNC_MUL],
			op_count[frac_pkg::FUNC_DIV], op_count[frac_pkg::FUNC_REDUCE], checked);
		$display("summary: %0d failures", fails);
		if (fails == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
